/* rtl/core/xpd_pkg.sv */
// Shared constants and types for the XNOR-popcount dot-product block.
`timescale 1ns / 1ps
`default_nettype none
package xpd_pkg;

    // Word and lane geometry
    localparam int WORD_BITS  = 32;
    localparam int LANES      = 4;
    localparam int LANE_BITS  = WORD_BITS / LANES;
    localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);
    localparam int CNT_W      = $clog2(WORD_BITS + 1);
    localparam int OFS_W      = $clog2(WORD_BITS);

    // Field and state widths
    localparam int FC_W    = 13;
    localparam int IDX_W   = 7;
    localparam int BASE_W  = IDX_W + OFS_W;
    localparam int SUM_W   = 13;
    localparam int DIFF_W  = SUM_W + 3;
    localparam int SCALE_W = 32;
    localparam int PROD_W  = DIFF_W + SCALE_W;
    localparam int OUT_W   = 45;

    // Reset value of the feature count register
    localparam logic [FC_W-1:0] FC_RESET = FC_W'(32);

    // Row word handed from the accumulator to the scaling stages
    typedef struct packed {
        logic signed [DIFF_W-1:0]  diff;
        logic signed [SCALE_W-1:0] scale;
    } xpd_row_t;

endpackage
`default_nettype wire

/* rtl/core/xpd_lane.sv */
// One lane: masked XNOR and popcount over a slice of the word.
`timescale 1ns / 1ps
`default_nettype none
module xpd_lane (
    input  logic [xpd_pkg::LANE_BITS-1:0]  weight_slice,
    input  logic [xpd_pkg::LANE_BITS-1:0]  act_slice,
    input  logic [xpd_pkg::LANE_BITS-1:0]  mask_slice,
    output logic [xpd_pkg::LANE_CNT_W-1:0] match_count
);
    import xpd_pkg::*;

    logic [LANE_BITS-1:0] agree;

    // Keep the agreeing positions that fall inside the row
    assign agree = ~(weight_slice ^ act_slice) & mask_slice;

    // Count them
    always_comb
    begin
        match_count = '0;
        for (int k = 0; k < LANE_BITS; k++)
        begin
            match_count = match_count + LANE_CNT_W'(agree[k]);
        end
    end

endmodule
`default_nettype wire

/* rtl/core/xpd_scale.sv */
// Scaling stages: signed multiply, saturation to 45 bits, output register.
`timescale 1ns / 1ps
`default_nettype none
module xpd_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 row_valid,
    input  xpd_pkg::xpd_row_t                    row,
    output logic                                 row_ready,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [xpd_pkg::OUT_W-1:0]     scaled_result
);
    import xpd_pkg::*;

    localparam int HI_W = PROD_W - OUT_W + 1;

    logic                       prod_valid_reg;
    logic                       prod_valid_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [OUT_W-1:0]    result_reg;
    logic signed [OUT_W-1:0]    result_next;
    logic                       out_ready;
    logic                       prod_ready;
    logic [HI_W-1:0]            prod_hi;

    // Stage handshakes: a stage loads when empty or when its word moves on
    assign out_ready  = !out_valid_reg || !out_stall;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign row_ready  = prod_ready;

    assign prod_valid_next = prod_ready ? row_valid : prod_valid_reg;
    assign out_valid_next  = out_ready ? prod_valid_reg : out_valid_reg;

    // Clamp the product to the signed output range
    assign prod_hi = prod_reg[PROD_W-1:OUT_W-1];
    always_comb
    begin
        if (prod_hi == '0 || prod_hi == '1)
        begin
            result_next = prod_reg[OUT_W-1:0];
        end
        else if (prod_reg[PROD_W-1])
        begin
            result_next = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            result_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: multiply, then hold the clamped result
    always_ff @(posedge clk)
    begin
        if (prod_ready && row_valid)
        begin
            prod_reg <= row.diff * row.scale;
        end
        if (out_ready && prod_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scaled_result = result_reg;

endmodule
`default_nettype wire

/* rtl/core/xnor_popcount_dot_scale.sv */
// Top level of the binary dot-product block with per-row scale.
`timescale 1ns / 1ps
`default_nettype none
// Binary neural-network dot product. Each input word carries 32 weight bits,
// 32 activation sign bits, a Q16.16 row scale and a last-word flag. Four
// lanes count the agreeing bit pairs of their eight-bit slices, masking
// features at or beyond feature_count; a merge stage adds the lane counts
// into the row's running match sum (saturating at 8191). On a row's last
// word the block delivers (2*sum - feature_count) * row_scale as a signed
// Q29.16 value clamped to 45 bits, and starts a new row. One word is taken
// every cycle unless a last word waits in stage 0 for the stages behind it;
// the match-sum accumulator adds the lane counts as a word leaves stage 0.
// Lane counts are registered as the word is taken, then merged into the row
// register, multiplied into the product register and clamped into the output
// register; words that are not a row's last flow on while a result waits
// to be taken. Write feature_count only while the block is idle.
module xnor_popcount_dot_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [xpd_pkg::FC_W-1:0]             cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [xpd_pkg::WORD_BITS-1:0]        weight_bits,
    input  logic [xpd_pkg::WORD_BITS-1:0]        act_bits,
    input  logic signed [xpd_pkg::SCALE_W-1:0]   row_scale,
    input  logic                                 last_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [xpd_pkg::OUT_W-1:0]     scaled_result
);
    import xpd_pkg::*;

    logic [FC_W-1:0]            fc_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;

    logic                       s0_valid_reg;
    logic                       s0_valid_next;
    logic [LANE_CNT_W-1:0]      s0_cnt_reg [LANES];
    logic                       s0_last_reg;
    logic signed [SCALE_W-1:0]  s0_scale_reg;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    xpd_row_t                   s1_row_reg;
    xpd_row_t                   s1_row_next;

    logic [LANE_CNT_W-1:0]      lane_cnt [LANES];
    logic [WORD_BITS-1:0]       mask;
    logic [BASE_W-1:0]          base;
    logic [FC_W-1:0]            remain;
    logic [CNT_W-1:0]           span;
    logic [CNT_W-1:0]           word_cnt;
    logic [SUM_W:0]             sum_raw;
    logic [SUM_W-1:0]           sum_sat;

    logic                       accept;
    logic                       s0_ready;
    logic                       s0_move;
    logic                       s1_ready;
    logic                       scl_ready;

    // Build the in-row mask from the word position
    assign base   = {idx_reg, {OFS_W{1'b0}}};
    assign remain = fc_reg - FC_W'(base);
    always_comb
    begin
        if (fc_reg <= FC_W'(base))
        begin
            span = '0;
        end
        else if (remain >= FC_W'(WORD_BITS))
        begin
            span = CNT_W'(WORD_BITS);
        end
        else
        begin
            span = remain[CNT_W-1:0];
        end
        for (int k = 0; k < WORD_BITS; k++)
        begin
            mask[k] = CNT_W'(k) < span;
        end
    end

    // Lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        xpd_lane u_lane (
            .weight_slice (weight_bits[g*LANE_BITS +: LANE_BITS]),
            .act_slice    (act_bits[g*LANE_BITS +: LANE_BITS]),
            .mask_slice   (mask[g*LANE_BITS +: LANE_BITS]),
            .match_count  (lane_cnt[g])
        );
    end

    // Pipeline handshakes; words that are not last leave stage 0 freely
    assign s1_ready      = !s1_valid_reg || scl_ready;
    assign s0_move       = s0_valid_reg && (!s0_last_reg || s1_ready);
    assign s0_ready      = !s0_valid_reg || s0_move;
    assign in_stall      = !s0_ready;
    assign accept        = in_valid && s0_ready;
    assign s0_valid_next = s0_ready ? in_valid : s0_valid_reg;
    assign s1_valid_next = (s0_move && s0_last_reg) ||
                           (s1_valid_reg && !scl_ready);

    // Advance the word position; wrap and restart on the last word
    assign idx_next = accept ? (last_word ? '0 : idx_reg + 1'b1) : idx_reg;

    // Merge the lane counts and saturate the running sum
    always_comb
    begin
        word_cnt = '0;
        for (int l = 0; l < LANES; l++)
        begin
            word_cnt = word_cnt + CNT_W'(s0_cnt_reg[l]);
        end
    end
    assign sum_raw = {1'b0, sum_reg} + (SUM_W+1)'(word_cnt);
    assign sum_sat = sum_raw[SUM_W] ? {SUM_W{1'b1}} : sum_raw[SUM_W-1:0];
    assign sum_next = s0_move ? (s0_last_reg ? '0 : sum_sat) : sum_reg;

    // Form the signed difference for a finished row
    always_comb
    begin
        s1_row_next.diff  = $signed({2'b00, sum_sat, 1'b0}) -
                            $signed({{(DIFF_W-FC_W){1'b0}}, fc_reg});
        s1_row_next.scale = s0_scale_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg       <= FC_RESET;
            idx_reg      <= '0;
            sum_reg      <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                fc_reg <= cfg_wdata;
            end
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s0_cnt_reg[l] <= lane_cnt[l];
            end
            s0_last_reg  <= last_word;
            s0_scale_reg <= row_scale;
        end
        if (s0_move && s0_last_reg)
        begin
            s1_row_reg <= s1_row_next;
        end
    end

    // Multiply, clamp and deliver
    xpd_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_valid     (s1_valid_reg),
        .row           (s1_row_reg),
        .row_ready     (scl_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_result (scaled_result)
    );

endmodule
`default_nettype wire

/* tb/xnor_popcount_dot_scale_test.sv */
// Self-checking testbench for the XNOR-popcount dot product with per-row scale.
`timescale 1ns / 1ps
module xnor_popcount_dot_scale_test;

    import xpd_pkg::*;

    localparam longint OUT_HI  = 64'sd17592186044415;
    localparam longint OUT_LO  = -64'sd17592186044416;
    localparam int     SUM_TOP = 8191;
    localparam int     SETTLE  = 8;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_WORDS   = 64;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wen = 1'b0;
    logic [FC_W-1:0]          cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [WORD_BITS-1:0]     weight_bits = '0;
    logic [WORD_BITS-1:0]     act_bits = '0;
    logic signed [SCALE_W-1:0] row_scale = '0;
    logic                     last_word = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [OUT_W-1:0]  scaled_result;

    // Shadow state of the block
    logic [FC_W-1:0]  feat_count = FC_RESET;
    int unsigned      match_total = 0;
    logic [IDX_W-1:0] word_pos = '0;

    logic signed [OUT_W-1:0] pending_scaled[$];
    int error_count = 0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;
    int stall_roll;

    xnor_popcount_dot_scale u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .weight_bits   (weight_bits),
        .act_bits      (act_bits),
        .row_scale     (row_scale),
        .last_word     (last_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_result (scaled_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one accepted word into the row sum; queue the scaled result on the last word
    function automatic void accumulate_word(input logic [31:0] w, input logic [31:0] a,
                                            input logic signed [31:0] s, input logic lw);
        int          base;
        int          fcv;
        logic [31:0] live;
        int unsigned sum;
        longint      diff;
        longint      prod;
        base = int'(word_pos) * WORD_BITS;
        fcv  = int'(feat_count);
        if (fcv <= base)
            live = '0;
        else if (fcv - base >= WORD_BITS)
            live = '1;
        else
            live = (32'd1 << (fcv - base)) - 32'd1;
        sum = match_total + $countones(~(w ^ a) & live);
        if (sum > SUM_TOP)
            sum = SUM_TOP;
        if (!lw)
        begin
            match_total = sum;
            word_pos    = word_pos + 1'b1;
        end
        else
        begin
            diff = 2 * longint'(sum) - longint'(feat_count);
            prod = diff * longint'(s);
            if (prod > OUT_HI)
                prod = OUT_HI;
            if (prod < OUT_LO)
                prod = OUT_LO;
            pending_scaled.push_back(prod[OUT_W-1:0]);
            match_total = 0;
            word_pos    = '0;
        end
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, and calm stretches
    function automatic int pick_gap();
        int r;
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            send_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void make_pair(output logic [31:0] w, output logic [31:0] a);
        int r;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 30)
            a = $urandom;
        else if (r < 50)
            a = w;
        else if (r < 60)
            a = ~w;
        else if (r < 85)
            a = w ^ (32'd1 << $urandom_range(0, 31)) ^ ($urandom & $urandom & $urandom);
        else
        begin
            w = (r < 92) ? 32'h0 : 32'hFFFF_FFFF;
            a = $urandom;
        end
    endfunction

    function automatic logic signed [31:0] make_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom;
        if (r < 80)
            return $urandom_range(0, 1) ? 32'sd1 * $urandom_range(1, 32'h20000)
                                        : -32'sd1 * $urandom_range(1, 32'h20000);
        if (r < 90)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                3:       return 32'sh0000_0001;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom_range(0, 1) ? 32'sh0001_0000 : 32'shFFFF_0000;
    endfunction

    // Present one word and hold it until the block takes it
    task automatic push_word(input logic [31:0] w, input logic [31:0] a,
                             input logic signed [31:0] s, input logic lw);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        weight_bits <= w;
        act_bits    <= a;
        row_scale   <= s;
        last_word   <= lw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_word(w, a, s, lw);
    endtask

    // Drop valid, wait for every queued result, then let the pipeline empty
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_scaled.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_feature_count(input logic [FC_W-1:0] value);
        drain_pipeline();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen    <= 1'b0;
        feat_count  = value;
    endtask

    // Send random rows until the word budget is spent; always finish the open row
    task automatic run_rows(input int budget);
        int          sent;
        int          need;
        int          len;
        int          r;
        logic [31:0] w;
        logic [31:0] a;
        sent = 0;
        need = (int'(feat_count) + WORD_BITS - 1) / WORD_BITS;
        if (need < 1)
            need = 1;
        if (need > 128)
            need = 128;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = need;
            else if (r < 85)
                len = $urandom_range(1, need);
            else if (r < 95)
                len = need + $urandom_range(1, 3);
            else
                len = $urandom_range(1, 200);
            for (int i = 0; i < len; i++)
            begin
                make_pair(w, a);
                push_word(w, a, make_scale(), i == len - 1);
            end
            sent += len;
        end
    endtask

    // Reset value of feature_count: extreme words and scales, masking of a second word
    task automatic test_default_count();
        push_word(32'h0000_0000, 32'h0000_0000, 32'sh0001_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 32'h0000_0000, 32'sh7FFF_FFFF, 1'b1);
        push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b1);
        push_word(32'hA5A5_A5A5, 32'hA5A5_0F0F, 32'sh1234_5678, 1'b0);
        push_word(32'h0000_0000, 32'h0000_0000, 32'shFFFF_FFFF, 1'b1);
    endtask

    // Partial words, a zero count and a count past the nominal maximum
    task automatic test_feature_masking();
        set_feature_count(FC_W'(1));
        push_word(32'hFFFF_FFFE, 32'h0000_0000, 32'sh0003_0000, 1'b1);
        push_word(32'h0000_0001, 32'h0000_0000, 32'sh0003_0000, 1'b1);
        set_feature_count(FC_W'(33));
        push_word(32'h5555_5555, 32'h5555_5555, 32'sh7FFF_0000, 1'b0);
        push_word(32'h0000_0001, 32'hFFFF_FFFF, 32'shFFFE_8000, 1'b1);
        set_feature_count(FC_W'(0));
        push_word(32'h0F0F_0F0F, 32'h0F0F_0F0F, 32'sh7FFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 32'h0000_0000, 32'sh8000_0000, 1'b1);
        set_feature_count(FC_W'(8191));
        push_word(32'hFFFF_FFFF, 32'h0000_0000, 32'sh8000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 32'h0000_0000, 32'sh8000_0000, 1'b1);
    endtask

    // Rows longer than the word index: sum saturation, result clamping, index wrap
    task automatic test_long_rows();
        logic [31:0] w;
        set_feature_count(FC_W'(4096));
        for (int i = 0; i < 257; i++)
        begin
            w = $urandom;
            push_word(w, w, 32'sh7FFF_FFFF, i == 256);
        end
        for (int i = 0; i < 257; i++)
        begin
            w = $urandom;
            push_word(w, w, 32'sh8000_0000, i == 256);
        end
        set_feature_count(FC_W'(40));
        for (int i = 0; i < 131; i++)
        begin
            w = $urandom;
            push_word(w, w, 32'sh0001_0000, i == 130);
        end
    endtask

    // Random rows over a sweep of feature counts
    task automatic test_random_rows();
        logic [FC_W-1:0] fixed_counts[8];
        logic [FC_W-1:0] fc;
        fixed_counts = '{FC_W'(32), FC_W'(1), FC_W'(0), FC_W'(8191),
                         FC_W'(4096), FC_W'(33), FC_W'(31), FC_W'(64)};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 8)
                fc = fixed_counts[p];
            else if ($urandom_range(0, 3) != 0)
                fc = $urandom_range(1, 4096);
            else
                fc = $urandom_range(4097, 8191);
            set_feature_count(fc);
            run_rows(PHASE_WORDS);
        end
    endtask

    // Random output backpressure with calm stretches
    always @(posedge clk)
    begin
        if (stall_calm > 0)
        begin
            stall_calm--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
                stall_calm = $urandom_range(20, 80);
            else if (stall_roll < 6)
                stall_left = $urandom_range(10, 30);
            else if (stall_roll < 35)
                stall_left = $urandom_range(1, 3);
            out_stall <= 1'b0;
        end
    end

    // Compare each delivered word with the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scaled.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, scaled_result);
                error_count++;
            end
            else if (scaled_result !== pending_scaled[0])
            begin
                $display("%0t: scaled_result expected %0d, actual %0d",
                         $time, pending_scaled[0], scaled_result);
                error_count++;
                void'(pending_scaled.pop_front());
            end
            else
                void'(pending_scaled.pop_front());
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_count();
        test_feature_masking();
        test_long_rows();
        test_random_rows();
        drain_pipeline();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("xnor_popcount_dot_scale: match");
        else
            $display("xnor_popcount_dot_scale: mismatch");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("xnor_popcount_dot_scale: mismatch");
        $finish;
    end

endmodule
